FILE: rtl/text_command_line_parser_defines.svh
// assertion macros used by the parser rtl
`ifndef TEXT_COMMAND_LINE_PARSER_DEFINES_SVH
`define TEXT_COMMAND_LINE_PARSER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TCLP_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TCLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tclp_pkg.sv
package tclp_pkg;

    // default magnitude width of a parsed number
    localparam int NUM_WIDTH_DEF = 32;
    // width of the result parameters
    localparam int PARAM_W = 32;

    // keyword table
    localparam int KW_COUNT   = 6;
    localparam int KW_MAX_LEN = 16;
    localparam int KW_MOVE    = 2;
    localparam int KW_SPEED   = 3;
    localparam int POS_W      = 5;

    localparam logic [KW_COUNT-1:0] KW_ALL       = 6'b111111;
    localparam logic [KW_COUNT-1:0] KW_PREFIX    = 6'b001100;
    localparam logic [KW_COUNT-1:0] KW_SEL_MOVE  = 6'b000100;
    localparam logic [KW_COUNT-1:0] KW_SEL_SPEED = 6'b001000;
    localparam logic [POS_W-1:0]    POS_MAX      = 5'd31;

    // keyword text, left aligned and zero padded
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"LED ON", 80'h0},
        {"LED OFF", 72'h0},
        {"SERVO MOVE:", 40'h0},
        "SERVO SET SPEED:",
        {"TRIGGER ON", 48'h0},
        {"TRIGGER OFF", 40'h0}
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd6, 5'd7, 5'd11, 5'd16, 5'd10, 5'd11
    };

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // command codes
    typedef enum logic [2:0] {
        CODE_NONE        = 3'd0,
        CODE_LIGHT_ON    = 3'd1,
        CODE_LIGHT_OFF   = 3'd2,
        CODE_SERVO_MOVE  = 3'd3,
        CODE_SERVO_SPEED = 3'd4,
        CODE_TRIG_ON     = 3'd5,
        CODE_TRIG_OFF    = 3'd6
    } cmd_t;

    // keyword matcher outcome for one character
    typedef struct packed {
        logic [KW_COUNT-1:0] cand;
        logic [POS_W-1:0]    pos;
        logic                prefix_hit;
        logic [KW_COUNT-1:0] prefix_cand;
        cmd_t                exact_code;
    } kw_result_t;

endpackage

FILE: rtl/text_command_line_parser.sv
// a character accepted into the input register is decoded from there into the parser
// state; a zero byte also writes its result word into the result register
// throughput: one character per cycle, set by the single decode step between the
// input register and the result register; a zero byte waits only while the
// result register still holds an untaken word
// reset: asynchronous, active low; parser returns to keyword matching, no result
`include "text_command_line_parser_defines.svh"

module text_command_line_parser #(
    parameter int NUM_WIDTH = tclp_pkg::NUM_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ch_valid,
    output logic                               ch_stall,
    input  logic [7:0]                         ch,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [2:0]                         command_code,
    output logic signed [tclp_pkg::PARAM_W-1:0] param_one,
    output logic signed [tclp_pkg::PARAM_W-1:0] param_two,
    output logic signed [tclp_pkg::PARAM_W-1:0] param_three
);
    import tclp_pkg::*;

    localparam int WIDE_W = NUM_WIDTH + 4;
    localparam logic [NUM_WIDTH-1:0] MAG_LIMIT = {1'b1, {(NUM_WIDTH-1){1'b0}}};
    localparam logic [NUM_WIDTH-1:0] POS_LIMIT = {1'b0, {(NUM_WIDTH-1){1'b1}}};

    typedef enum logic [4:0] {
        PH_KEYWORD = 5'b00001,
        PH_PRE     = 5'b00010,
        PH_NUM     = 5'b00100,
        PH_AFTER   = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // input register
    logic       ch_valid_reg;
    logic [7:0] ch_reg;

    // parser state
    phase_t                     phase_reg, phase_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [KW_COUNT-1:0]        cand_reg, cand_next;
    logic [1:0]                 index_reg, index_next;
    logic [NUM_WIDTH-1:0]       acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic                       digit_reg, digit_next;
    logic                       failed_reg, failed_next;
    logic signed [NUM_WIDTH-1:0] value_reg [3];
    logic signed [NUM_WIDTH-1:0] value_next [3];

    // result register
    logic                       result_valid_reg, result_valid_next;
    cmd_t                       code_reg, code_next;
    logic signed [PARAM_W-1:0]  param_one_reg, param_one_next;
    logic signed [PARAM_W-1:0]  param_two_reg, param_two_next;
    logic signed [PARAM_W-1:0]  param_three_reg, param_three_next;

    logic                       go;
    logic                       line_end;
    logic                       is_digit;
    logic                       is_ws;
    logic [3:0]                 digit_val;
    logic [NUM_WIDTH-1:0]       acc_base;
    logic [WIDE_W-1:0]          acc_wide;
    logic [NUM_WIDTH-1:0]       acc_digit;
    logic signed [NUM_WIDTH-1:0] cur_value;
    logic                       needs_three;
    logic [1:0]                 index_inc;
    logic [1:0]                 needed;
    logic                       store_en;
    logic                       final_store;
    logic signed [NUM_WIDTH-1:0] sel_value [3];
    kw_result_t                 kw;

    // handshake: only a line end can be held up by the result register
    assign go       = ch_valid_reg && ((ch_reg != CH_NUL) || !result_valid_reg || !result_stall);
    assign ch_stall = ch_valid_reg && !go;
    assign line_end = ch_reg == CH_NUL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg <= 1'b0;
        end
        else if (!ch_stall)
        begin
            ch_valid_reg <= ch_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ch_stall)
        begin
            ch_reg <= ch;
        end
    end

    // keyword matcher
    tclp_kw_match u_kw_match (
        .cand   (cand_reg),
        .pos    (pos_reg),
        .ch     (ch_reg),
        .result (kw)
    );

    // character classes
    assign is_digit  = ch_reg inside {[CH_ZERO:CH_NINE]};
    assign is_ws     = (ch_reg == CH_SPACE) || (ch_reg inside {[CH_TAB:CH_CR]});
    assign digit_val = ch_reg[3:0];

    // accumulator times ten plus digit, saturated at the magnitude limit
    assign acc_base  = (phase_reg == PH_PRE) ? '0 : acc_reg;
    assign acc_wide  = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + WIDE_W'(digit_val);
    assign acc_digit = (acc_wide > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc_wide[NUM_WIDTH-1:0];

    // signed value of the number being read
    assign cur_value = neg_reg ? NUM_WIDTH'('0 - acc_reg)
                               : ((acc_reg > POS_LIMIT) ? POS_LIMIT : acc_reg);

    assign needs_three = cand_reg[KW_SPEED];
    assign needed      = needs_three ? 2'd3 : 2'd2;
    assign index_inc   = index_reg + 2'd1;
    assign final_store = (phase_reg == PH_NUM) && digit_reg && (index_inc == needed);

    // stored values with the pending number folded in at line end
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sel_value[i] = (final_store && index_reg == 2'(i)) ? cur_value : value_reg[i];
        end
    end

    // parser next state
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        index_next  = index_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        digit_next  = digit_reg;
        failed_next = failed_reg;
        store_en    = 1'b0;
        if (go && line_end)
        begin
            phase_next  = PH_KEYWORD;
            pos_next    = '0;
            cand_next   = KW_ALL;
            index_next  = '0;
            acc_next    = '0;
            neg_next    = 1'b0;
            digit_next  = 1'b0;
            failed_next = 1'b0;
        end
        else if (go && !failed_reg)
        begin
            case (phase_reg)
                PH_KEYWORD:
                begin
                    cand_next = kw.cand;
                    pos_next  = kw.pos;
                    if (kw.cand == '0)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (kw.prefix_hit)
                    begin
                        cand_next  = kw.prefix_cand;
                        phase_next = PH_PRE;
                        index_next = '0;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        digit_next = 1'b0;
                    end
                end
                PH_PRE:
                begin
                    if (!is_ws)
                    begin
                        phase_next = PH_NUM;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        digit_next = 1'b0;
                        if (ch_reg == CH_MINUS)
                        begin
                            neg_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_digit;
                            digit_next = 1'b1;
                        end
                        else if (ch_reg != CH_PLUS)
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                PH_NUM:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_digit;
                        digit_next = 1'b1;
                    end
                    else if (!digit_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        store_en   = 1'b1;
                        index_next = index_inc;
                        if (index_inc >= needed)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (ch_reg == CH_COMMA)
                        begin
                            phase_next = PH_PRE;
                        end
                        else if (is_ws)
                        begin
                            phase_next = PH_AFTER;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
                PH_AFTER:
                begin
                    if (ch_reg == CH_COMMA)
                    begin
                        phase_next = PH_PRE;
                    end
                    else if (!is_ws)
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // value store write
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            value_next[i] = value_reg[i];
            if (go && line_end)
            begin
                value_next[i] = '0;
            end
            else if (store_en && index_reg == 2'(i))
            begin
                value_next[i] = cur_value;
            end
        end
    end

    // result word at line end
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        code_next         = code_reg;
        param_one_next    = param_one_reg;
        param_two_next    = param_two_reg;
        param_three_next  = param_three_reg;
        if (go && line_end)
        begin
            result_valid_next = 1'b1;
            code_next         = CODE_NONE;
            param_one_next    = '0;
            param_two_next    = '0;
            param_three_next  = '0;
            if (!failed_reg)
            begin
                if (phase_reg == PH_KEYWORD)
                begin
                    code_next = kw.exact_code;
                end
                else if ((phase_reg == PH_DONE) || final_store)
                begin
                    code_next      = needs_three ? CODE_SERVO_SPEED : CODE_SERVO_MOVE;
                    param_one_next = PARAM_W'(sel_value[0]);
                    param_two_next = PARAM_W'(sel_value[1]);
                    if (needs_three)
                    begin
                        param_three_next = PARAM_W'(sel_value[2]);
                    end
                end
            end
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_KEYWORD;
            pos_reg          <= '0;
            cand_reg         <= KW_ALL;
            index_reg        <= '0;
            acc_reg          <= '0;
            neg_reg          <= 1'b0;
            digit_reg        <= 1'b0;
            failed_reg       <= 1'b0;
            value_reg        <= '{default: '0};
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            cand_reg         <= cand_next;
            index_reg        <= index_next;
            acc_reg          <= acc_next;
            neg_reg          <= neg_next;
            digit_reg        <= digit_next;
            failed_reg       <= failed_next;
            value_reg        <= value_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg        <= code_next;
        param_one_reg   <= param_one_next;
        param_two_reg   <= param_two_next;
        param_three_reg <= param_three_next;
    end

    // outputs
    assign result_valid = result_valid_reg;
    assign command_code = code_reg;
    assign param_one    = param_one_reg;
    assign param_two    = param_two_reg;
    assign param_three  = param_three_reg;

    // checks
    `TCLP_ASSERT_HOLD(a_params_zero,
        result_valid_reg && code_reg != CODE_SERVO_MOVE && code_reg != CODE_SERVO_SPEED,
        param_one_reg == '0 && param_two_reg == '0 && param_three_reg == '0,
        "non-servo result carries nonzero parameters")
    `TCLP_ASSERT_HOLD(a_move_two_params,
        result_valid_reg && code_reg == CODE_SERVO_MOVE,
        param_three_reg == '0,
        "servo move result carries a third parameter")
    `TCLP_ASSERT_NEXT(a_line_end_clears,
        go && line_end,
        phase_reg == PH_KEYWORD && cand_reg == KW_ALL && pos_reg == '0 && !failed_reg,
        "parser state not cleared after line end")
    `TCLP_ASSERT_HOLD(a_number_single_cmd,
        phase_reg != PH_KEYWORD,
        cand_reg == KW_SEL_MOVE || cand_reg == KW_SEL_SPEED,
        "number phase without a single servo command selected")

endmodule

FILE: rtl/tclp_kw_match.sv
module tclp_kw_match (
    input  logic [tclp_pkg::KW_COUNT-1:0] cand,
    input  logic [tclp_pkg::POS_W-1:0]    pos,
    input  logic [7:0]                    ch,
    output tclp_pkg::kw_result_t          result
);
    import tclp_pkg::*;

    logic [3:0]       rpos;
    logic [POS_W-1:0] pos_inc;

    // byte index, counted from the low end, of the character at pos inside the padded text
    assign rpos    = 4'(KW_MAX_LEN - 1) - pos[3:0];
    assign pos_inc = (pos == POS_MAX) ? pos : pos + 5'd1;

    // candidate filter, prefix completion and exact line match
    always_comb
    begin
        result             = '0;
        result.pos         = pos_inc;
        result.exact_code  = CODE_NONE;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            result.cand[k] = cand[k] && !pos[4] &&
                             (KW_TEXT[k][{rpos, 3'b000} +: 8] == ch);
        end
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (KW_PREFIX[k] && result.cand[k] && pos_inc == KW_LEN[k])
            begin
                result.prefix_hit  = 1'b1;
                result.prefix_cand = KW_COUNT'(1) << k;
            end
            if (!KW_PREFIX[k] && cand[k] && pos == KW_LEN[k])
            begin
                result.exact_code = cmd_t'(3'(k + 1));
            end
        end
    end

endmodule

FILE: tb/text_command_line_parser_tb.sv
module text_command_line_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tclp_pkg::*;

    localparam int IDLE_PCT     = 11;
    localparam int RANDOM_CHARS = 1400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LINE_CASES   = 18;

    // signed range of a parsed number
    localparam logic [63:0] POS_CAP = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_CAP = 64'h0000_0000_8000_0000;

    // keyword set, in code order
    localparam int KEY_COUNT = 6;
    localparam int KEY_SPEED = 3;
    localparam int POS_SAT   = 31;
    localparam logic [KEY_COUNT-1:0] KEY_ALL    = 6'b111111;
    localparam logic [KEY_COUNT-1:0] KEY_PREFIX = 6'b001100;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    typedef enum logic [2:0] {
        ST_KEYWORD,
        ST_PRE,
        ST_NUM,
        ST_AFTER,
        ST_DONE
    } scan_state_t;

    typedef struct packed {
        cmd_t        code;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
    } line_result_t;

    typedef struct {
        string        text;
        bit           pinned;
        line_result_t want;
    } line_case_t;

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic ch_valid     = 1'b0;
    logic [7:0] ch     = 8'h00;
    logic result_stall = 1'b0;
    logic ch_stall;
    logic result_valid;
    logic [2:0] command_code;
    logic signed [PARAM_W-1:0] param_one;
    logic signed [PARAM_W-1:0] param_two;
    logic signed [PARAM_W-1:0] param_three;

    string key_text [KEY_COUNT] = '{
        "LED ON", "LED OFF", "SERVO MOVE:", "SERVO SET SPEED:", "TRIGGER ON", "TRIGGER OFF"
    };
    cmd_t key_code [KEY_COUNT] = '{
        CODE_LIGHT_ON, CODE_LIGHT_OFF, CODE_SERVO_MOVE, CODE_SERVO_SPEED,
        CODE_TRIG_ON, CODE_TRIG_OFF
    };

    // parser shadow state
    int unsigned          key_pos;
    logic [KEY_COUNT-1:0] key_live;
    scan_state_t          scan;
    int unsigned          num_slot;
    logic [63:0]          magnitude;
    bit                   minus;
    bit                   got_digit;
    logic [31:0]          values [3];
    bit                   line_dead;

    line_result_t expected_lines [$];
    line_result_t head;
    int errors = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    // directed lines; typed results only where obvious
    line_case_t directed_lines [LINE_CASES] = '{
        '{"LED ON", 1'b1, '{CODE_LIGHT_ON, 32'd0, 32'd0, 32'd0}},
        '{"LED OFF", 1'b1, '{CODE_LIGHT_OFF, 32'd0, 32'd0, 32'd0}},
        '{"TRIGGER ON", 1'b1, '{CODE_TRIG_ON, 32'd0, 32'd0, 32'd0}},
        '{"TRIGGER OFF", 1'b1, '{CODE_TRIG_OFF, 32'd0, 32'd0, 32'd0}},
        '{"", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"LED ON ", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"LED O", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"SERVO MOVE:12,-34", 1'b1, '{CODE_SERVO_MOVE, 32'd12, -32'sd34, 32'd0}},
        '{"SERVO SET SPEED:+1 ,\t2\013,\r-3 tail", 1'b0, '0},
        '{"SERVO MOVE:99999999999,-99999999999", 1'b1,
          '{CODE_SERVO_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0}},
        '{"SERVO MOVE:2147483648,-2147483649", 1'b0, '0},
        '{"SERVO MOVE:-,5", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"SERVO MOVE:7", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"SERVO SET SPEED:1,2", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"SERVO MOVEMENT IS NOT A COMMAND AT ALL!!", 1'b1,
          '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"\377\200\177\001", 1'b1, '{CODE_NONE, 32'd0, 32'd0, 32'd0}},
        '{"SERVO MOVE:\014\n 0 , 0\n", 1'b0, '0},
        '{"SERVO MOVE:1,2,3", 1'b0, '0}
    };

    text_command_line_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch_valid     (ch_valid),
        .ch_stall     (ch_stall),
        .ch           (ch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .command_code (command_code),
        .param_one    (param_one),
        .param_two    (param_two),
        .param_three  (param_three)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // line predictor
    // ---------------------------------------------------------------

    function automatic void number_open();
        magnitude = '0;
        minus     = 1'b0;
        got_digit = 1'b0;
    endfunction

    function automatic void scan_clear();
        key_pos   = 0;
        key_live  = KEY_ALL;
        scan      = ST_KEYWORD;
        num_slot  = 0;
        number_open();
        values[0] = '0;
        values[1] = '0;
        values[2] = '0;
        line_dead = 1'b0;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int unsigned numbers_wanted();
        return key_live[KEY_SPEED] ? 3 : 2;
    endfunction

    // decimal accumulate, pinned at the negative magnitude limit
    function automatic void push_digit(logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - CH_ZERO};
        if (magnitude > (NEG_CAP - d) / 10)
            magnitude = NEG_CAP;
        else
            magnitude = magnitude * 10 + d;
        got_digit = 1'b1;
    endfunction

    function automatic void number_close();
        logic [63:0] v;
        if (minus)
            v = -magnitude;
        else
            v = (magnitude > POS_CAP) ? POS_CAP : magnitude;
        if (num_slot < 3)
            values[num_slot] = v[31:0];
    endfunction

    function automatic void match_keyword(logic [7:0] c);
        logic [KEY_COUNT-1:0] hits;
        int unsigned p;
        hits = '0;
        p    = key_pos;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (key_live[k] && p < key_text[k].len() && key_text[k][p] == c)
                hits[k] = 1'b1;
        end
        key_live = hits;
        key_pos  = (p < POS_SAT) ? p + 1 : POS_SAT;
        if (hits == '0)
        begin
            line_dead = 1'b1;
            return;
        end
        // a completed prefix keyword switches to number scanning
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (KEY_PREFIX[k] && hits[k] && p + 1 == key_text[k].len())
            begin
                key_live = '0;
                key_live[k] = 1'b1;
                scan = ST_PRE;
                num_slot = 0;
                number_open();
            end
        end
    endfunction

    function automatic void scan_number(logic [7:0] c);
        bit digit;
        digit = (c >= CH_ZERO && c <= CH_NINE);
        case (scan)
            ST_PRE:
            begin
                if (!is_blank(c))
                begin
                    number_open();
                    scan = ST_NUM;
                    if (c == CH_MINUS)
                        minus = 1'b1;
                    else if (digit)
                        push_digit(c);
                    else if (c != CH_PLUS)
                        line_dead = 1'b1;
                end
            end
            ST_NUM:
            begin
                if (digit)
                    push_digit(c);
                else if (!got_digit)
                    line_dead = 1'b1;
                else
                begin
                    number_close();
                    num_slot = (num_slot + 1) % 4;
                    if (num_slot >= numbers_wanted())
                        scan = ST_DONE;
                    else if (c == CH_COMMA)
                        scan = ST_PRE;
                    else if (is_blank(c))
                        scan = ST_AFTER;
                    else
                        line_dead = 1'b1;
                end
            end
            ST_AFTER:
            begin
                if (c == CH_COMMA)
                    scan = ST_PRE;
                else if (!is_blank(c))
                    line_dead = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // result for the line ended by a zero byte, then back to a clean line
    function automatic line_result_t line_verdict();
        line_result_t r;
        int unsigned n;
        bit ok;
        r = '0;
        r.code = CODE_NONE;
        if (!line_dead)
        begin
            if (scan == ST_KEYWORD)
            begin
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    if (!KEY_PREFIX[k] && key_live[k] && key_pos == key_text[k].len())
                        r.code = key_code[k];
                end
            end
            else
            begin
                n  = numbers_wanted();
                ok = (scan == ST_DONE);
                if (scan == ST_NUM && got_digit && num_slot + 1 == n)
                begin
                    number_close();
                    ok = 1'b1;
                end
                if (ok)
                begin
                    r.code = (n == 3) ? CODE_SERVO_SPEED : CODE_SERVO_MOVE;
                    r.p1   = values[0];
                    r.p2   = values[1];
                    r.p3   = (n == 3) ? values[2] : '0;
                end
            end
        end
        scan_clear();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // character sender
    // ---------------------------------------------------------------

    task automatic send_char(input logic [7:0] c, input bit pinned, input line_result_t want);
        line_result_t res;
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            ch_valid <= 1'b0;
            @(negedge clk);
        end
        ch       <= c;
        ch_valid <= 1'b1;
        @(posedge clk);
        while (ch_stall)
            @(posedge clk);
        // word taken: advance the shadow parser
        if (c == CH_NUL)
        begin
            res = line_verdict();
            expected_lines.push_back(pinned ? want : res);
        end
        else if (!line_dead)
        begin
            if (scan == ST_KEYWORD)
                match_keyword(c);
            else
                scan_number(c);
        end
    endtask

    task automatic send_line(input string text, input bit pinned, input line_result_t want);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], 1'b0, '0);
        send_char(CH_NUL, pinned, want);
    endtask

    // stop sending and let every pending result drain
    task automatic wait_for_results();
        @(negedge clk);
        ch_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // random line builders
    // ---------------------------------------------------------------

    function automatic string blanks(int most);
        string s;
        s = "";
        repeat ($urandom_range(most))
            s = {s, $sformatf("%c", BLANKS[$urandom_range(5)])};
        return s;
    endfunction

    function automatic string noise_text(int most, int lo, int hi);
        string s;
        s = "";
        repeat ($urandom_range(most))
            s = {s, $sformatf("%c", 8'($urandom_range(hi, lo)))};
        return s;
    endfunction

    // optional blanks and sign, mostly short digit runs, some long enough to saturate
    function automatic string random_number();
        string s;
        int sign_roll;
        int len;
        s = ($urandom_range(3) == 0) ? blanks(3) : "";
        sign_roll = $urandom_range(3);
        if (sign_roll == 0)
            s = {s, "-"};
        else if (sign_roll == 1)
            s = {s, "+"};
        len = ($urandom_range(7) == 0) ? $urandom_range(14, 9) : $urandom_range(4, 1);
        repeat (len)
            s = {s, $sformatf("%0d", $urandom_range(9))};
        return s;
    endfunction

    function automatic string servo_line(bit three);
        string s;
        int n;
        n = three ? 3 : 2;
        s = three ? "SERVO SET SPEED:" : "SERVO MOVE:";
        for (int i = 0; i < n; i++)
        begin
            s = {s, random_number()};
            if (i < n - 1)
            begin
                if ($urandom_range(3) == 0)
                    s = {s, blanks(2)};
                s = {s, ","};
            end
        end
        if ($urandom_range(3) == 0)
            s = {s, noise_text(6, 32, 126)};
        return s;
    endfunction

    // cut the line short or overwrite one character
    function automatic string mangle(string s);
        int k;
        if (s.len() == 0)
            return s;
        k = $urandom_range(s.len() - 1);
        if ($urandom_range(1) == 0)
            return s.substr(0, k - 1);
        s[k] = 8'($urandom_range(255, 1));
        return s;
    endfunction

    function automatic string random_line();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return servo_line(1'b0);
        else if (roll < 60)
            return servo_line(1'b1);
        else if (roll < 75)
        begin
            if ($urandom_range(3) == 0)
                return mangle(key_text[$urandom_range(KEY_COUNT - 1)]);
            case ($urandom_range(3))
                0: return key_text[0];
                1: return key_text[1];
                2: return key_text[4];
                default: return key_text[5];
            endcase
        end
        else if (roll < 90)
            return mangle(servo_line(1'($urandom_range(1))));
        return noise_text(40, 1, 255);
    endfunction

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial
    begin
        string text;
        int random_sent;
        int lines;
        random_sent = 0;
        lines = 0;
        scan_clear();
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_lines[i])
            send_line(directed_lines[i].text, directed_lines[i].pinned, directed_lines[i].want);

        while (random_sent < RANDOM_CHARS)
        begin
            // one stretch runs with no idling on either side
            calm = (lines >= 20 && lines < 35);
            if (lines == 12 || lines == 45)
                wait_for_results();
            text = random_line();
            send_line(text, 1'b0, '0);
            random_sent += text.len() + 1;
            lines++;
        end

        calm = 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------
    // result receiver and checker
    // ---------------------------------------------------------------

    // random stall on the result side
    always @(negedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
        return 1;
    endfunction

    // compare each taken result word with the oldest expected line
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_lines.size() == 0)
            begin
                $error("result word with no line pending: code %0d", command_code);
                errors++;
            end
            else
            begin
                head = expected_lines.pop_front();
                if (head.code !== command_code)
                begin
                    $error("command_code: expected %0d, actual %0d", head.code, command_code);
                    errors++;
                end
                errors += field_check("param_one", head.p1, param_one);
                errors += field_check("param_two", head.p2, param_two);
                errors += field_check("param_three", head.p3, param_three);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ch_valid && !ch_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tclp_pkg.sv
rtl/tclp_kw_match.sv
rtl/text_command_line_parser.sv
tb/text_command_line_parser_tb.sv
